// ===== hw/rtl/case_insensitive_byte_sorter_unit_assert.svh =====
// Assertion macros for the byte sorter RTL
`ifndef CASE_INSENSITIVE_BYTE_SORTER_UNIT_ASSERT_SVH
`define CASE_INSENSITIVE_BYTE_SORTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge out of reset
`define CISB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cisb: implication check failed");
// Next-cycle implication, checked on every rising edge out of reset
`define CISB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cisb: next-cycle check failed");
`else
`define CISB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CISB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/cisb_pkg.sv =====
// Types, constants and key function for the byte sorter
`default_nettype none

package cisb_pkg;

    localparam int BYTE_W   = 8;
    localparam int PREFIX_W = 7;

    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 7'd64;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Case folding bounds
    localparam logic [BYTE_W-1:0] UPPER_A     = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z     = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } in_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } out_beat_t;

    // One classified input beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              keep;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PASS,
        B_SCAN,
        B_SWAP_HI,
        B_SWAP_LO,
        B_EMIT
    } b_state_t;

    // Sort key: fold upper case to lower case, read as a signed byte
    function automatic logic signed [BYTE_W-1:0] fold_key(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        begin
            v = b;
            if (b >= UPPER_A && b <= UPPER_Z) begin
                v = b + CASE_OFFSET;
            end
            fold_key = $signed(v);
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cisb_front.sv =====
// Front end: accept input beats and mark those that fit in the buffer
`default_nettype none

module cisb_front #(
    parameter int MaxLen = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cisb_pkg::in_beat_t s_data,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output cisb_pkg::cmd_t         cmd_data
);

    localparam int CntW = $clog2(MaxLen + 1);

    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic            keep;
    logic            accept;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;

    // Classify: bytes beyond the buffer size are dropped, last still ends the string
    assign keep = (cnt_reg < CntW'(MaxLen));

    always_comb begin
        cmd_data.data = s_data.in_byte;
        cmd_data.last = s_data.in_last;
        cmd_data.keep = keep;
    end

    // Advance the per-string count, restart after the last beat
    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            if (s_data.in_last) begin
                cnt_next = '0;
            end else if (keep) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cisb_queue.sv =====
// Short command queue between the front end and the sort engine
`default_nettype none

module cisb_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire cisb_pkg::cmd_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output cisb_pkg::cmd_t      pop_data
);

    cisb_pkg::cmd_t                    slot_reg [cisb_pkg::QDEPTH];
    logic [cisb_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [cisb_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [cisb_pkg::QCNT_W-1:0]       cnt_reg;
    logic [cisb_pkg::QCNT_W-1:0]       cnt_next;
    logic                              push;
    logic                              pop;

    assign push_ready = (cnt_reg != cisb_pkg::QCNT_W'(cisb_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Hold entries until popped
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cisb_back.sv =====
// Back end: string buffer, selection sort engine and output register
`default_nettype none
`include "case_insensitive_byte_sorter_unit_assert.svh"

module cisb_back #(
    parameter int MaxLen = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [cisb_pkg::PREFIX_W-1:0]       prefix_len,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire cisb_pkg::cmd_t                      cmd_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output cisb_pkg::out_beat_t                      m_data
);

    localparam int CntW  = $clog2(MaxLen + 1);
    localparam int AddrW = $clog2(MaxLen);

    // Buffer memory, one write and one registered read per cycle
    logic [cisb_pkg::BYTE_W-1:0] char_mem [MaxLen];
    logic [cisb_pkg::BYTE_W-1:0] rdata_reg;
    logic                        mem_we;
    logic [AddrW-1:0]            mem_wa;
    logic [cisb_pkg::BYTE_W-1:0] mem_wd;
    logic                        mem_re;
    logic [AddrW-1:0]            mem_ra;

    cisb_pkg::b_state_t state_reg, state_next;

    logic [CntW-1:0]             cnt_reg, cnt_next;
    logic [CntW-1:0]             len_reg, len_next;
    logic [CntW-1:0]             n_reg, n_next;
    logic [CntW-1:0]             i_reg, i_next;
    logic [CntW-1:0]             j_reg, j_next;
    logic                        pend_vld_reg, pend_vld_next;
    logic [CntW-1:0]             pend_idx_reg, pend_idx_next;
    logic                        first_reg, first_next;
    logic [cisb_pkg::BYTE_W-1:0] best_val_reg, best_val_next;
    logic [CntW-1:0]             best_idx_reg, best_idx_next;
    logic [cisb_pkg::BYTE_W-1:0] ival_reg, ival_next;
    logic                        out_vld_reg, out_vld_next;
    cisb_pkg::out_beat_t         out_data_reg, out_data_next;

    logic [CntW-1:0]             len_sum;
    logic [CntW-1:0]             i_inc;
    logic [CntW-1:0]             j_inc;
    logic                        more_pass;
    logic                        issue;
    logic                        out_free;
    logic                        last_byte;
    logic                        key_less;

    assign len_sum   = cnt_reg + CntW'(cmd_data.keep);
    assign i_inc     = i_reg + 1'b1;
    assign j_inc     = j_reg + 1'b1;
    assign more_pass = (i_inc < n_reg);
    assign issue     = (state_reg == cisb_pkg::B_SCAN) && (j_reg < n_reg);
    assign out_free  = !out_vld_reg || m_ready;
    assign last_byte = (j_inc == len_reg);
    assign key_less  = (cisb_pkg::fold_key(rdata_reg) < cisb_pkg::fold_key(best_val_reg));

    assign cmd_ready = (state_reg == cisb_pkg::B_IDLE);
    assign m_valid   = out_vld_reg;
    assign m_data    = out_data_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cisb_pkg::B_IDLE: begin
                if (cmd_valid && cmd_data.last) begin
                    state_next = cisb_pkg::B_PASS;
                end
            end
            cisb_pkg::B_PASS: begin
                state_next = more_pass ? cisb_pkg::B_SCAN : cisb_pkg::B_EMIT;
            end
            cisb_pkg::B_SCAN: begin
                if (!issue && !pend_vld_reg) begin
                    state_next = cisb_pkg::B_SWAP_HI;
                end
            end
            cisb_pkg::B_SWAP_HI: state_next = cisb_pkg::B_SWAP_LO;
            cisb_pkg::B_SWAP_LO: state_next = cisb_pkg::B_PASS;
            cisb_pkg::B_EMIT: begin
                if (out_free && last_byte) begin
                    state_next = cisb_pkg::B_IDLE;
                end
            end
            default: state_next = cisb_pkg::B_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pend_vld_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        first_next    = first_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        ival_next     = ival_reg;
        out_data_next = out_data_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        mem_we        = 1'b0;
        mem_wa        = cnt_reg[AddrW-1:0];
        mem_wd        = cmd_data.data;
        mem_re        = 1'b0;
        mem_ra        = j_reg[AddrW-1:0];
        case (state_reg)
            cisb_pkg::B_IDLE: begin
                // Store the beat if kept; on last, latch length and sort size
                if (cmd_valid) begin
                    if (cmd_data.keep) begin
                        mem_we   = 1'b1;
                        cnt_next = len_sum;
                    end
                    if (cmd_data.last) begin
                        cnt_next = '0;
                        len_next = len_sum;
                        i_next   = '0;
                        if (cisb_pkg::PREFIX_W'(len_sum) > prefix_len) begin
                            n_next = CntW'(prefix_len);
                        end else begin
                            n_next = len_sum;
                        end
                    end
                end
            end
            cisb_pkg::B_PASS: begin
                // Start a scan from i, or start reading out the string
                if (more_pass) begin
                    j_next     = i_reg;
                    first_next = 1'b1;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = '0;
                    j_next = '0;
                end
            end
            cisb_pkg::B_SCAN: begin
                // Read one entry a cycle, compare the one read last cycle
                if (issue) begin
                    mem_re = 1'b1;
                    j_next = j_inc;
                end
                pend_vld_next = issue;
                pend_idx_next = j_reg;
                if (pend_vld_reg) begin
                    if (first_reg) begin
                        best_val_next = rdata_reg;
                        best_idx_next = pend_idx_reg;
                        ival_next     = rdata_reg;
                        first_next    = 1'b0;
                    end else if (key_less) begin
                        best_val_next = rdata_reg;
                        best_idx_next = pend_idx_reg;
                    end
                end
            end
            cisb_pkg::B_SWAP_HI: begin
                mem_we = 1'b1;
                mem_wa = best_idx_reg[AddrW-1:0];
                mem_wd = ival_reg;
            end
            cisb_pkg::B_SWAP_LO: begin
                mem_we = 1'b1;
                mem_wa = i_reg[AddrW-1:0];
                mem_wd = best_val_reg;
                i_next = i_inc;
            end
            cisb_pkg::B_EMIT: begin
                // Load the output register and prefetch the next byte
                if (out_free) begin
                    out_vld_next           = 1'b1;
                    out_data_next.out_byte = rdata_reg;
                    out_data_next.out_last = last_byte;
                    if (!last_byte) begin
                        mem_re = 1'b1;
                        mem_ra = j_inc[AddrW-1:0];
                        j_next = j_inc;
                    end
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cisb_pkg::B_IDLE;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        pend_idx_reg <= pend_idx_next;
        first_reg    <= first_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        ival_reg     <= ival_next;
        out_data_reg <= out_data_next;
    end

    // Buffer memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            char_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg <= char_mem[mem_ra];
        end
    end

    `CISB_ASSERT_IMP(a_best_in_range, aclk, aresetn, (state_reg == cisb_pkg::B_SCAN) && !first_reg, (best_idx_reg >= i_reg) && (best_idx_reg < n_reg))
    `CISB_ASSERT_IMP(a_sort_within_len, aclk, aresetn, state_reg != cisb_pkg::B_IDLE, (n_reg <= len_reg) && (len_reg != '0))
    `CISB_ASSERT_IMP(a_emit_in_range, aclk, aresetn, state_reg == cisb_pkg::B_EMIT, j_reg < len_reg)
    `CISB_ASSERT_NXT(a_end_marks_last, aclk, aresetn, (state_reg == cisb_pkg::B_EMIT) && (state_next == cisb_pkg::B_IDLE), out_vld_reg && out_data_reg.out_last)

endmodule

`default_nettype wire

// ===== hw/rtl/case_insensitive_byte_sorter_unit.sv =====
// Input beats are taken one a cycle while the 4-entry command queue has room.
// After the last beat, N bytes are sorted (no scan for N below 2),
// bounded by the single-port buffer read (one comparison a cycle), then the
// L bytes of the string leave one beat a cycle while m_ready is high.
// Reset (aresetn low, synchronous): control cleared, sort prefix length set to 64;
// the buffer contents are left as they are, no clearing pass.
`default_nettype none

module case_insensitive_byte_sorter_unit #(
    parameter int MaxLen = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire cisb_pkg::in_beat_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output cisb_pkg::out_beat_t                    m_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [cisb_pkg::PREFIX_W-1:0]     cfg_wr_data
);

    logic [cisb_pkg::PREFIX_W-1:0] prefix_reg;

    logic           f_valid, f_ready;
    cisb_pkg::cmd_t f_data;
    logic           q_valid, q_ready;
    cisb_pkg::cmd_t q_data;

    // Sort prefix length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= cisb_pkg::PREFIX_RESET;
        end else if (cfg_wr_en) begin
            prefix_reg <= cfg_wr_data;
        end
    end

    cisb_front #(
        .MaxLen(MaxLen)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    cisb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    cisb_back #(
        .MaxLen(MaxLen)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .prefix_len (prefix_reg),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .cmd_data   (q_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
